// ===== hw/rtl/lds_pkg.sv =====
package lds_pkg;

   // Widths of the transaction fields on the channels.
   localparam int FIELD_BITS  = 31;
   localparam int RESULT_BITS = 64;

   // Sequencer states of the solver core.
   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_EUC_DIV   = 8'b0000_0010,
      ST_MUL_S     = 8'b0000_0100,
      ST_MUL_T     = 8'b0000_1000,
      ST_SCALE_DIV = 8'b0001_0000,
      ST_MUL_X     = 8'b0010_0000,
      ST_MUL_Y     = 8'b0100_0000,
      ST_RESP      = 8'b1000_0000
   } state_type;

endpackage

// ===== hw/rtl/lds_req_if.sv =====
interface lds_req_if;
   logic                            valid;
   logic                            ready;
   logic [lds_pkg::FIELD_BITS-1:0]  coef_a;
   logic [lds_pkg::FIELD_BITS-1:0]  coef_b;
   logic [lds_pkg::FIELD_BITS-1:0]  rhs_c;

   modport source (output valid, coef_a, coef_b, rhs_c, input ready);
   modport sink   (input valid, coef_a, coef_b, rhs_c, output ready);
endinterface

// ===== hw/rtl/lds_rsp_if.sv =====
interface lds_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  solvable;
   logic        [lds_pkg::FIELD_BITS-1:0]  divisor;
   logic signed [lds_pkg::RESULT_BITS-1:0] sol_x;
   logic signed [lds_pkg::RESULT_BITS-1:0] sol_y;

   modport source (output valid, solvable, divisor, sol_x, sol_y, input ready);
   modport sink   (input valid, solvable, divisor, sol_x, sol_y, output ready);
endinterface

// ===== hw/rtl/lds_divider.sv =====
module lds_divider #(
   parameter int WIDTH = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // Restoring division, one quotient bit per cycle. The dividend shifts
   // out of the top of the quotient register while quotient bits enter below.
   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (diff[WIDTH]) begin
            rem_in = shifted[WIDTH-1:0];
         end else begin
            rem_in = diff[WIDTH-1:0];
         end
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/linear_diophantine_solver_core.sv =====
// Each Euclid step runs one pass of the shared divider and two multiply passes; the final
// scaling adds one more divide and two more multiply passes.
// Throughput: one transaction at a time; the next is taken after the result is delivered.
// Reset: synchronous, active high; returns the sequencer and the divider control to idle, no data is cleared.
module linear_diophantine_solver_core #(
   parameter int OPERAND_BITS = 31
) (
   input logic         clock,
   input logic         reset,
   lds_req_if.sink     req_chan,
   lds_rsp_if.source   rsp_chan
);

   // Bezout coefficients stay below 2^OPERAND_BITS in magnitude, and so do
   // the intermediate values of a Euclid step; two extra bits hold the sign
   // and the headroom of the difference.
   localparam int CB = OPERAND_BITS + 2;
   localparam int AW = lds_pkg::RESULT_BITS;

   lds_pkg::state_type state_ff, state_in;
   logic div_start_ff, div_start_in;

   // Euclid remainders, the latched quotient/remainder of the current step,
   // and the right-hand side.
   logic [OPERAND_BITS-1:0] r0_ff, r0_in;
   logic [OPERAND_BITS-1:0] r1_ff, r1_in;
   logic [OPERAND_BITS-1:0] q_ff, q_in;
   logic [OPERAND_BITS-1:0] rem_ff, rem_in;
   logic [OPERAND_BITS-1:0] c_ff, c_in;

   // Bezout coefficient pairs.
   logic signed [CB-1:0] s0_ff, s0_in;
   logic signed [CB-1:0] s1_ff, s1_in;
   logic signed [CB-1:0] t0_ff, t0_in;
   logic signed [CB-1:0] t1_ff, t1_in;

   // Shared multiply unit: acc <= acc - mcand * mplier, one multiplier bit
   // per cycle, finishing as soon as no set bit is left in the multiplier.
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [AW-1:0]    mcand_ff, mcand_in;
   logic [OPERAND_BITS-1:0] mplier_ff, mplier_in;
   logic signed [AW-1:0]    mac_addend;
   logic signed [AW-1:0]    mac_next;
   logic                    mac_run;

   // Result register; it holds the transaction until the sink takes it.
   logic                    solv_ff, solv_in;
   logic [OPERAND_BITS-1:0] gcd_ff, gcd_in;
   logic signed [AW-1:0]    x_ff, x_in;
   logic signed [AW-1:0]    y_ff, y_in;

   // Operands as seen by the block: bits above OPERAND_BITS are ignored.
   logic [OPERAND_BITS-1:0] in_a;
   logic [OPERAND_BITS-1:0] in_b;
   logic [OPERAND_BITS-1:0] in_c;

   // Divider hookup. During the Euclid steps it divides r0 by r1; for the
   // final scaling it divides c by the gcd, which then sits in r0.
   logic [OPERAND_BITS-1:0] div_num;
   logic [OPERAND_BITS-1:0] div_den;
   logic                    div_done;
   logic [OPERAND_BITS-1:0] div_quo;
   logic [OPERAND_BITS-1:0] div_rem;

   assign in_a = req_chan.coef_a[OPERAND_BITS-1:0];
   assign in_b = req_chan.coef_b[OPERAND_BITS-1:0];
   assign in_c = req_chan.rhs_c[OPERAND_BITS-1:0];

   assign div_num = (state_ff == lds_pkg::ST_SCALE_DIV) ? c_ff  : r0_ff;
   assign div_den = (state_ff == lds_pkg::ST_SCALE_DIV) ? r0_ff : r1_ff;

   lds_divider #(
      .WIDTH (OPERAND_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign mac_addend = mplier_ff[0] ? mcand_ff : '0;
   assign mac_next   = acc_ff - mac_addend;
   assign mac_run    = (mplier_ff != '0);

   always_comb begin
      state_in     = state_ff;
      div_start_in = 1'b0;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      c_in         = c_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      solv_in      = solv_ff;
      gcd_in       = gcd_ff;
      x_in         = x_ff;
      y_in         = y_ff;

      unique case (state_ff)
         lds_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if ((in_a == '0) && (in_b == '0)) begin
                  // No gcd exists when both coefficients are zero.
                  solv_in  = 1'b0;
                  gcd_in   = '0;
                  x_in     = '1;
                  y_in     = '1;
                  state_in = lds_pkg::ST_RESP;
               end else begin
                  r0_in        = in_a;
                  r1_in        = in_b;
                  c_in         = in_c;
                  s0_in        = CB'(1);
                  s1_in        = '0;
                  t0_in        = '0;
                  t1_in        = CB'(1);
                  div_start_in = 1'b1;
                  // With b zero the gcd is a itself and x0 = 1, y0 = 0.
                  state_in     = (in_b == '0) ? lds_pkg::ST_SCALE_DIV
                                              : lds_pkg::ST_EUC_DIV;
               end
            end
         end

         lds_pkg::ST_EUC_DIV: begin
            if (div_done) begin
               q_in      = div_quo;
               rem_in    = div_rem;
               acc_in    = AW'(s0_ff);
               mcand_in  = AW'(s1_ff);
               mplier_in = div_quo;
               state_in  = lds_pkg::ST_MUL_S;
            end
         end

         lds_pkg::ST_MUL_S: begin
            if (mac_run) begin
               acc_in    = mac_next;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               s0_in     = s1_ff;
               s1_in     = acc_ff[CB-1:0];
               acc_in    = AW'(t0_ff);
               mcand_in  = AW'(t1_ff);
               mplier_in = q_ff;
               state_in  = lds_pkg::ST_MUL_T;
            end
         end

         lds_pkg::ST_MUL_T: begin
            if (mac_run) begin
               acc_in    = mac_next;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               // Close the Euclid step and shift the remainder pair.
               t0_in        = t1_ff;
               t1_in        = acc_ff[CB-1:0];
               r0_in        = r1_ff;
               r1_in        = rem_ff;
               div_start_in = 1'b1;
               state_in     = (rem_ff == '0) ? lds_pkg::ST_SCALE_DIV
                                             : lds_pkg::ST_EUC_DIV;
            end
         end

         lds_pkg::ST_SCALE_DIV: begin
            if (div_done) begin
               gcd_in = r0_ff;
               if (div_rem != '0) begin
                  // The gcd does not divide c: no integer solution.
                  solv_in  = 1'b0;
                  x_in     = '1;
                  y_in     = '1;
                  state_in = lds_pkg::ST_RESP;
               end else begin
                  // The unit subtracts, so the negated coefficient yields x0 * k.
                  solv_in   = 1'b1;
                  q_in      = div_quo;
                  acc_in    = '0;
                  mcand_in  = -AW'(s0_ff);
                  mplier_in = div_quo;
                  state_in  = lds_pkg::ST_MUL_X;
               end
            end
         end

         lds_pkg::ST_MUL_X: begin
            if (mac_run) begin
               acc_in    = mac_next;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               x_in      = acc_ff;
               acc_in    = '0;
               mcand_in  = -AW'(t0_ff);
               mplier_in = q_ff;
               state_in  = lds_pkg::ST_MUL_Y;
            end
         end

         lds_pkg::ST_MUL_Y: begin
            if (mac_run) begin
               acc_in    = mac_next;
               mcand_in  = mcand_ff <<< 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               y_in     = acc_ff;
               state_in = lds_pkg::ST_RESP;
            end
         end

         lds_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = lds_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lds_pkg::ST_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      c_ff      <= c_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      solv_ff   <= solv_in;
      gcd_ff    <= gcd_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

   // A request transaction is taken only in idle; the result transaction is
   // offered from the result register until the sink accepts it.
   assign req_chan.ready    = (state_ff == lds_pkg::ST_IDLE);
   assign rsp_chan.valid    = (state_ff == lds_pkg::ST_RESP);
   assign rsp_chan.solvable = solv_ff;
   assign rsp_chan.divisor  = lds_pkg::FIELD_BITS'(gcd_ff);
   assign rsp_chan.sol_x    = x_ff;
   assign rsp_chan.sol_y    = y_ff;

endmodule
